FILE: rtl/msp_pkg.sv
`timescale 1ns / 1ps

package msp_pkg;

    // Text limit per region; a region keeps at most MAX_TEXT-1 bytes.
    localparam int MAX_TEXT = 128;
    localparam int CNT_W = $clog2(MAX_TEXT);
    localparam int LEN_W = 7;

    // Hold window: '%', '{', up to BODY_MAX body bytes, and the byte under test.
    localparam int BODY_MAX = 7;
    localparam int HOLD_LIMIT = 2 + BODY_MAX;
    localparam int HOLD_DEPTH = HOLD_LIMIT + 1;
    localparam int HOLD_W = $clog2(HOLD_DEPTH + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

    // Configuration port
    localparam int ADDR_W = 3;
    localparam int REG_IDX_LSB = 2;
    localparam int REG_IDX_W = ADDR_W - REG_IDX_LSB;
    localparam logic [REG_IDX_W-1:0] REG_DELIM = '0;
    localparam logic [7:0] DELIM_RESET = 8'h09;

    localparam logic [1:0] REGION_FIRST = 2'd0;
    localparam logic [1:0] REGION_LAST = 2'd2;

    localparam logic [7:0] CH_PCT = 8'h25;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_DASH = 8'h2D;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_LO_A = 8'h61;
    localparam logic [7:0] CH_LO_F = 8'h66;
    localparam logic [7:0] CH_UP_A = 8'h41;
    localparam logic [7:0] CH_UP_F = 8'h46;
    localparam logic [7:0] HEX_TEN = 8'd10;

    localparam logic [1:0] CMD_BYTE = 2'd0;
    localparam logic [1:0] CMD_CLOSE = 2'd1;
    localparam logic [1:0] CMD_EOS = 2'd2;

    localparam logic KIND_TEXT = 1'b0;
    localparam logic KIND_END = 1'b1;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic [1:0] op;
        logic [1:0] region;
        t_byte      data;
    } t_cmd;

    typedef struct packed {
        logic             kind;
        logic [1:0]       region;
        t_byte            text;
        logic [23:0]      color;
        logic             cvalid;
        logic [LEN_W-1:0] len;
    } t_rec;

    typedef struct packed {
        t_rec rec;
        logic last;
    } t_res;

    // {ok, nibble}
    function automatic logic [4:0] hex_nib(input t_byte c);
        logic [7:0] v;
        logic       ok;
        v = '0;
        ok = 1'b0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            v = c - CH_ZERO;
            ok = 1'b1;
        end else if (c >= CH_LO_A && c <= CH_LO_F) begin
            v = c - CH_LO_A + HEX_TEN;
            ok = 1'b1;
        end else if (c >= CH_UP_A && c <= CH_UP_F) begin
            v = c - CH_UP_A + HEX_TEN;
            ok = 1'b1;
        end
        return {ok, v[3:0]};
    endfunction

endpackage

FILE: rtl/markup_text_section_parser.sv
`timescale 1ns / 1ps

// Markup section parser: push one string byte per request (or an end-of-string
// marker) and pop text records and region end records in order; last_of_run
// flags the final record caused by each request. The intake queue holds two
// requests and the result queue two records, so both sides stall on their own;
// a full result queue freezes the scanner in place.
// The scanner takes one command per item and walks the ten-byte hold window one
// byte per cycle while the result queue is not full: a plain byte means taking
// the command, scanning the byte, finding the window drained and closing the
// run, and every byte rescanned after a rejected tag adds a scan step. A
// delimiter or end of string means taking the command, a step per held byte, a
// step per end record (up to three) and closing the run.
module markup_text_section_parser import msp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              push,
    output logic              full,
    input  logic [7:0]        i_in_byte,
    input  logic              i_end_of_string,
    output logic              empty,
    input  logic              pop,
    output logic              o_record_kind,
    output logic [1:0]        o_region_index,
    output logic [7:0]        o_text_byte,
    output logic [23:0]       o_region_color,
    output logic              o_color_valid,
    output logic [LEN_W-1:0]  o_text_length,
    output logic              o_last_of_run
);

    logic cmd_vld, cmd_pop;
    t_cmd cmd;
    logic q_push, q_rdy, q_vld;
    t_res q_in, q_out;

    msp_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_prdata        (prdata),
        .o_pready        (pready),
        .i_push          (push),
        .o_full          (full),
        .i_in_byte       (i_in_byte),
        .i_end_of_string (i_end_of_string),
        .o_cmd_vld       (cmd_vld),
        .o_cmd           (cmd),
        .i_cmd_pop       (cmd_pop)
    );

    msp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd_vld (cmd_vld),
        .i_cmd     (cmd),
        .o_cmd_pop (cmd_pop),
        .o_q_push  (q_push),
        .o_q_data  (q_in),
        .i_q_rdy   (q_rdy)
    );

    msp_resq u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_rdy   (q_rdy),
        .o_vld   (q_vld),
        .o_data  (q_out),
        .i_pop   (pop)
    );

    assign empty          = !q_vld;
    assign o_record_kind  = q_out.rec.kind;
    assign o_region_index = q_out.rec.region;
    assign o_text_byte    = q_out.rec.text;
    assign o_region_color = q_out.rec.color;
    assign o_color_valid  = q_out.rec.cvalid;
    assign o_text_length  = q_out.rec.len;
    assign o_last_of_run  = q_out.last;

`ifndef ASSERT_OFF
    a_region_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_region_index != 2'd3)
        else $error("result region index out of range");

    a_text_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_record_kind == KIND_TEXT) |->
            (o_region_color == 24'd0 && !o_color_valid && o_text_length == '0))
        else $error("text record carries end-record fields");

    a_pop_needs_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> cmd_vld)
        else $error("scanner took a command from an empty intake queue");

    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> empty)
        else $error("result queue not empty after reset");
`endif

endmodule

FILE: rtl/msp_front.sv
`timescale 1ns / 1ps

module msp_front import msp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [ADDR_W-1:0] i_paddr,
    input  logic [31:0]       i_pwdata,
    output logic [31:0]       o_prdata,
    output logic              o_pready,
    input  logic              i_push,
    output logic              o_full,
    input  t_byte             i_in_byte,
    input  logic              i_end_of_string,
    output logic              o_cmd_vld,
    output t_cmd              o_cmd,
    input  logic              i_cmd_pop
);

    logic [7:0]          r_delim;
    logic [1:0]          r_region, n_region;
    t_cmd                r_q [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wp, r_rp;
    logic [QUEUE_AW:0]   r_n;
    t_cmd                cls;
    logic                accept;
    logic                cfg_wr;
    logic                idx_hit;

    assign idx_hit  = (i_paddr[ADDR_W-1:REG_IDX_LSB] == REG_DELIM);
    assign cfg_wr   = i_psel && i_penable && i_pwrite && o_pready && idx_hit;
    assign o_pready = 1'b1;
    assign o_prdata = idx_hit ? {24'd0, r_delim} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim <= DELIM_RESET;
        end else if (cfg_wr) begin
            r_delim <= i_pwdata[7:0];
        end
    end

    // Region tracking happens here so the delimiter rule is settled at intake.
    always_comb begin
        cls.data   = i_in_byte;
        cls.region = r_region;
        n_region   = r_region;
        if (i_end_of_string) begin
            cls.op   = CMD_EOS;
            n_region = REGION_FIRST;
        end else if (i_in_byte == r_delim && r_region != REGION_LAST) begin
            cls.op   = CMD_CLOSE;
            n_region = r_region + 2'd1;
        end else begin
            cls.op = CMD_BYTE;
        end
    end

    assign o_full    = (r_n == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign accept    = i_push && !o_full;
    assign o_cmd_vld = (r_n != '0);
    assign o_cmd     = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region <= REGION_FIRST;
            r_wp     <= '0;
            r_rp     <= '0;
            r_n      <= '0;
        end else begin
            if (accept) begin
                r_region <= n_region;
                r_wp     <= r_wp + QUEUE_AW'(1);
            end
            if (i_cmd_pop) begin
                r_rp <= r_rp + QUEUE_AW'(1);
            end
            r_n <= r_n + (QUEUE_AW + 1)'(accept) - (QUEUE_AW + 1)'(i_cmd_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wp] <= cls;
        end
    end

endmodule

FILE: rtl/msp_back.sv
`timescale 1ns / 1ps

module msp_back import msp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cmd_vld,
    input  t_cmd i_cmd,
    output logic o_cmd_pop,
    output logic o_q_push,
    output t_res o_q_data,
    input  logic i_q_rdy
);

    typedef logic [HOLD_DEPTH-1:0][7:0] t_buf;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_RUN    = 2'd1;
    localparam logic [1:0] ST_TAIL   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    localparam logic [2:0] SH_NONE = 3'd0;
    localparam logic [2:0] SH_ONE  = 3'd1;
    localparam logic [2:0] SH_TWO  = 3'd2;
    localparam logic [2:0] SH_DASH = 3'd3;
    localparam logic [2:0] SH_HEX  = 3'd4;

    // "%{-}" is matched with '%', '{', '-' held
    localparam int DASH_HC = 3;

    function automatic t_buf shift_by(input t_buf b, input int s);
        t_buf o;
        o = b;
        for (int k = 0; k < HOLD_DEPTH; k++) begin
            if (k + s < HOLD_DEPTH) begin
                o[k] = b[k + s];
            end
        end
        return o;
    endfunction

    logic [1:0]       r_state, n_state;
    t_buf             r_buf, n_buf;
    logic [HOLD_W-1:0] r_len, n_len;
    logic [HOLD_W-1:0] r_hc, n_hc;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [23:0]      r_color, n_color;
    logic             r_cset, n_cset;
    logic [1:0]       r_region, n_region;
    logic             r_closing, n_closing;
    logic             r_eos, n_eos;
    t_rec             r_stg;
    logic             r_stg_vld, n_stg_vld;

    t_byte            cur;
    logic             have;
    logic             text_ok;
    logic             tag_dash, tag_hex;
    logic [23:0]      hex_val;
    logic [4:0]       nib;
    logic [2:0]       sh_sel;
    logic             buf_wr;
    logic             emit, last_push, do_fail, text_req;
    t_byte            text_char;
    t_rec             new_rec;
    logic             need_q, stall;

    assign cur     = r_buf[r_hc];
    assign have    = (r_hc < r_len);
    assign text_ok = (r_cnt < CNT_W'(MAX_TEXT - 1));

    always_comb begin
        hex_val = '0;
        tag_hex = (r_hc == HOLD_W'(HOLD_LIMIT)) && (r_buf[2] == CH_HASH);
        for (int i = 0; i < 6; i++) begin
            nib = hex_nib(r_buf[3 + i]);
            tag_hex = tag_hex && nib[4];
            hex_val = {hex_val[19:0], nib[3:0]};
        end
        tag_dash = (r_hc == HOLD_W'(DASH_HC)) && (r_buf[2] == CH_DASH);
    end

    always_comb begin
        n_state   = r_state;
        n_len     = r_len;
        n_hc      = r_hc;
        n_cnt     = r_cnt;
        n_color   = r_color;
        n_cset    = r_cset;
        n_region  = r_region;
        n_closing = r_closing;
        n_eos     = r_eos;
        sh_sel    = SH_NONE;
        buf_wr    = 1'b0;
        o_cmd_pop = 1'b0;
        emit      = 1'b0;
        last_push = 1'b0;
        do_fail   = 1'b0;
        text_req  = 1'b0;
        text_char = cur;
        new_rec   = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_vld) begin
                    o_cmd_pop = 1'b1;
                    n_region  = i_cmd.region;
                    n_state   = ST_RUN;
                    unique case (i_cmd.op)
                        CMD_BYTE: begin
                            buf_wr    = 1'b1;
                            n_len     = r_len + HOLD_W'(1);
                            n_closing = 1'b0;
                            n_eos     = 1'b0;
                        end
                        CMD_CLOSE: begin
                            n_closing = 1'b1;
                            n_eos     = 1'b0;
                        end
                        CMD_EOS: begin
                            n_closing = 1'b1;
                            n_eos     = 1'b1;
                        end
                        default: begin
                            n_closing = 1'b0;
                            n_eos     = 1'b0;
                        end
                    endcase
                end
            end
            ST_RUN: begin
                if (have) begin
                    if (r_hc == '0) begin
                        if (cur == CH_PCT) begin
                            n_hc = HOLD_W'(1);
                        end else begin
                            text_req = 1'b1;
                            sh_sel   = SH_ONE;
                        end
                    end else if (r_hc == HOLD_W'(1)) begin
                        if (cur == CH_PCT) begin
                            text_req  = 1'b1;
                            text_char = CH_PCT;
                            n_hc      = '0;
                            sh_sel    = SH_TWO;
                        end else if (cur == CH_LBRACE) begin
                            n_hc = HOLD_W'(2);
                        end else begin
                            do_fail = 1'b1;
                        end
                    end else if (cur == CH_RBRACE) begin
                        if (tag_dash) begin
                            n_color = '0;
                            n_cset  = 1'b0;
                            n_hc    = '0;
                            sh_sel  = SH_DASH;
                        end else if (tag_hex) begin
                            n_color = hex_val;
                            n_cset  = 1'b1;
                            n_hc    = '0;
                            sh_sel  = SH_HEX;
                        end else begin
                            do_fail = 1'b1;
                        end
                    end else if (r_hc < HOLD_W'(HOLD_LIMIT)) begin
                        n_hc = r_hc + HOLD_W'(1);
                    end else begin
                        do_fail = 1'b1;
                    end
                end else if (r_closing) begin
                    if (r_hc != '0) begin
                        // pending tag at region end turns literal
                        do_fail = 1'b1;
                    end else begin
                        emit           = 1'b1;
                        new_rec.kind   = KIND_END;
                        new_rec.region = r_region;
                        new_rec.color  = r_cset ? r_color : '0;
                        new_rec.cvalid = r_cset;
                        new_rec.len    = LEN_W'(r_cnt);
                        n_color        = '0;
                        n_cset         = 1'b0;
                        n_cnt          = '0;
                        n_closing      = 1'b0;
                        if (r_eos && r_region != REGION_LAST) begin
                            n_region = r_region + 2'd1;
                            n_state  = ST_TAIL;
                        end else begin
                            n_eos   = 1'b0;
                            n_state = ST_FINISH;
                        end
                    end
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_TAIL: begin
                emit           = 1'b1;
                new_rec.kind   = KIND_END;
                new_rec.region = r_region;
                if (r_region == REGION_LAST) begin
                    n_eos    = 1'b0;
                    n_region = REGION_FIRST;
                    n_state  = ST_FINISH;
                end else begin
                    n_region = r_region + 2'd1;
                end
            end
            ST_FINISH: begin
                last_push = 1'b1;
                n_state   = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Failed tag: '%' goes out, the rest is rescanned from the byte after it.
        if (do_fail) begin
            text_req  = 1'b1;
            text_char = CH_PCT;
            n_hc      = '0;
            sh_sel    = SH_ONE;
        end

        if (text_req && text_ok) begin
            emit           = 1'b1;
            new_rec        = '0;
            new_rec.kind   = KIND_TEXT;
            new_rec.region = r_region;
            new_rec.text   = text_char;
            n_cnt          = r_cnt + CNT_W'(1);
        end

        case (sh_sel)
            SH_ONE:  n_len = r_len - HOLD_W'(1);
            SH_TWO:  n_len = r_len - HOLD_W'(2);
            SH_DASH: n_len = r_len - HOLD_W'(DASH_HC + 1);
            SH_HEX:  n_len = r_len - HOLD_W'(HOLD_DEPTH);
            default: ;
        endcase
    end

    always_comb begin
        case (sh_sel)
            SH_ONE:  n_buf = shift_by(r_buf, 1);
            SH_TWO:  n_buf = shift_by(r_buf, 2);
            SH_DASH: n_buf = shift_by(r_buf, DASH_HC + 1);
            SH_HEX:  n_buf = shift_by(r_buf, HOLD_DEPTH);
            default: n_buf = r_buf;
        endcase
    end

    // One record waits in the stage so the last one of a run can be flagged.
    assign need_q   = r_stg_vld && (emit || last_push);
    assign stall    = need_q && !i_q_rdy;
    assign o_q_push = need_q && i_q_rdy;
    assign o_q_data = '{rec: r_stg, last: last_push};

    always_comb begin
        n_stg_vld = r_stg_vld;
        if (emit) begin
            n_stg_vld = 1'b1;
        end else if (last_push) begin
            n_stg_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_len     <= '0;
            r_hc      <= '0;
            r_cnt     <= '0;
            r_color   <= '0;
            r_cset    <= 1'b0;
            r_region  <= REGION_FIRST;
            r_closing <= 1'b0;
            r_eos     <= 1'b0;
            r_stg_vld <= 1'b0;
        end else if (!stall) begin
            r_state   <= n_state;
            r_len     <= n_len;
            r_hc      <= n_hc;
            r_cnt     <= n_cnt;
            r_color   <= n_color;
            r_cset    <= n_cset;
            r_region  <= n_region;
            r_closing <= n_closing;
            r_eos     <= n_eos;
            r_stg_vld <= n_stg_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall) begin
            if (buf_wr) begin
                r_buf[r_len] <= i_cmd.data;
            end else begin
                r_buf <= n_buf;
            end
            if (emit) begin
                r_stg <= new_rec;
            end
        end
    end

endmodule

FILE: rtl/msp_resq.sv
`timescale 1ns / 1ps

module msp_resq import msp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_res i_data,
    output logic o_rdy,
    output logic o_vld,
    output t_res o_data,
    input  logic i_pop
);

    t_res                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wp, r_rp;
    logic [QUEUE_AW:0]   r_n;
    logic                wr, rd;

    assign o_rdy  = (r_n != (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_vld  = (r_n != '0);
    assign o_data = r_mem[r_rp];
    assign wr     = i_push && o_rdy;
    assign rd     = i_pop && o_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_n  <= '0;
        end else begin
            if (wr) begin
                r_wp <= r_wp + QUEUE_AW'(1);
            end
            if (rd) begin
                r_rp <= r_rp + QUEUE_AW'(1);
            end
            r_n <= r_n + (QUEUE_AW + 1)'(wr) - (QUEUE_AW + 1)'(rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule
